### rtl/periodic_timer_bank_core_macros.svh
// Assertion macros for the periodic timer bank checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef PERIODIC_TIMER_BANK_CORE_MACROS_SVH
`define PERIODIC_TIMER_BANK_CORE_MACROS_SVH

// property checked outside reset
`define PTB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked on every edge, reset included
`define PTB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

### rtl/ptb_pkg.sv
// Shared types and constants of the periodic timer bank.
// No dependencies; imported by every module of the block except ptb_ram.
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int NUM_SLOTS     = 64;
   localparam int MS_PER_SECOND = 1000;

   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
   localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);

   localparam int FUNC_W       = 2;
   localparam int PERIOD_W     = 24;
   localparam int SLOT_W       = 6;
   localparam int STATUS_W     = 3;
   localparam int SEC_W        = 13;
   localparam int COUNT_W      = 7;
   localparam int MAX_PERIOD_W = 23;
   localparam int RAM_W        = 2 * SEC_W;

   localparam int MAX_RESULTS  = 64;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [SEC_W-1:0]        SEC_MAX          = '1;
   localparam logic [COUNT_W-1:0]      MAX_ACTIVE_RESET = COUNT_W'(50);
   localparam logic [MAX_PERIOD_W-1:0] MAX_PERIOD_RESET = MAX_PERIOD_W'(5000000);

   // ms to seconds: multiply by a rounded-up reciprocal, exact for any accepted period
   localparam int MS_SHIFT = MAX_PERIOD_W + $clog2(MS_PER_SECOND);
   localparam longint unsigned MS_RECIP =
      ((64'd1 << MS_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND;
   localparam int RECIP_W = MAX_PERIOD_W + 1;
   localparam int PROD_W  = MAX_PERIOD_W + RECIP_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_ACTIVE    = 2'd0,
      CSR_MAX_PERIOD_MS = 2'd1
   } csr_index_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_PERIOD = 3'd1,
      ST_FULL       = 3'd2,
      ST_BAD_SLOT   = 3'd3,
      ST_EXPIRY     = 3'd4,
      ST_NO_EXPIRY  = 3'd5
   } status_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [PERIOD_W-1:0] period_ms;
      logic [SLOT_W-1:0]   slot_in;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_out;
      logic              last;
   } rsp_type;

   typedef struct packed {
      func_type                op;
      logic                    bad_period;
      logic [MAX_PERIOD_W-1:0] secs;
      logic [SLOT_W-1:0]       slot_in;
   } cmd_type;

endpackage

### rtl/ptb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ptb_front.sv
// Front end: accepts request words, checks the period and converts it to seconds.
// Depends on ptb_pkg.
`timescale 1ns / 1ps

module ptb_front import ptb_pkg::*; (
   input  logic                    push,
   input  req_type                 req_word,
   output logic                    full,
   input  logic [MAX_PERIOD_W-1:0] max_period_ms,
   output logic                    cmd_push,
   output cmd_type                 cmd_word,
   input  logic                    cmd_full
);

   logic              func_known;
   logic [PROD_W-1:0] prod;

   assign func_known = (req_word.func == FUNC_START) || (req_word.func == FUNC_STOP) ||
                       (req_word.func == FUNC_TICK);

   // unknown function codes are swallowed here
   assign full     = cmd_full;
   assign cmd_push = push && !cmd_full && func_known;

   assign prod = PROD_W'(req_word.period_ms[MAX_PERIOD_W-1:0]) * PROD_W'(MS_RECIP);

   assign cmd_word.op         = func_type'(req_word.func);
   assign cmd_word.bad_period = (req_word.period_ms < PERIOD_W'(MS_PER_SECOND)) ||
                                (req_word.period_ms > PERIOD_W'(max_period_ms));
   assign cmd_word.secs       = MAX_PERIOD_W'(prod >> MS_SHIFT);
   assign cmd_word.slot_in    = req_word.slot_in;

endmodule

### rtl/ptb_cmd_fifo.sv
// Short command queue between the front end and the slot engine.
// Depends on ptb_pkg.
`timescale 1ns / 1ps

module ptb_cmd_fifo import ptb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_word,
   output logic    full,
   input  logic    rd_en,
   output cmd_type rd_word,
   output logic    empty
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_word = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

### rtl/ptb_back.sv
// Slot engine: occupancy flags, second counters in RAM, tick walk and result queue.
// Depends on ptb_pkg and ptb_ram.
`timescale 1ns / 1ps

module ptb_back import ptb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd_word,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  logic [COUNT_W-1:0] max_active,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_word
);

   localparam int RQ_PTR_W = $clog2(RSP_DEPTH);
   localparam int RQ_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_START_SCAN,
      S_TICK_SCAN,
      S_TICK_DONE
   } state_type;

   function automatic rsp_type make_rsp(status_type st, logic [SLOT_W-1:0] s, logic l);
      rsp_type r;
      r.status   = st;
      r.slot_out = s;
      r.last     = l;
      return r;
   endfunction

   state_type               state_ff, state_in;
   logic [SLOT_CNT_W-1:0]   scan_ff, scan_in;
   logic [SLOT_IDX_W-1:0]   scan_idx;
   logic                    p_valid_ff, p_valid_in;
   logic [SLOT_IDX_W-1:0]   p_slot_ff, p_slot_in;
   logic [NUM_SLOTS-1:0]    used_ff, used_in;
   logic [NUM_SLOTS-1:0]    active_ff, active_in;
   logic [COUNT_W-1:0]      used_count_ff, used_count_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [SLOT_IDX_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [RESULT_CNT_W-1:0] exp_cnt_ff, exp_cnt_in;

   rsp_type                 rq_ff [RSP_DEPTH];
   logic [RQ_PTR_W-1:0]     rq_wr_ff, rq_wr_in;
   logic [RQ_PTR_W-1:0]     rq_rd_ff, rq_rd_in;
   logic [RQ_CNT_W-1:0]     rq_cnt_ff, rq_cnt_in;
   logic                    room, rsp_taken;
   logic                    push_rsp;
   rsp_type                 push_word;

   logic                    ram_wr_en, ram_rd_en;
   logic [SLOT_IDX_W-1:0]   ram_wr_addr;
   logic [RAM_W-1:0]        ram_wr_data, ram_rd_data;
   logic [SEC_W-1:0]        ram_rem, ram_reload, rem_dec;

   logic [SEC_W-1:0]        secs_sat;
   logic                    stop_ok;
   logic [SLOT_IDX_W-1:0]   stop_idx;
   logic                    p_used, p_active;

   ptb_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx),
      .rd_data (ram_rd_data)
   );

   assign scan_idx   = scan_ff[SLOT_IDX_W-1:0];
   assign ram_rem    = ram_rd_data[SEC_W-1:0];
   assign ram_reload = ram_rd_data[RAM_W-1:SEC_W];
   assign rem_dec    = ram_rem - SEC_W'(1);
   assign p_used     = used_ff[p_slot_ff];
   assign p_active   = active_ff[p_slot_ff];
   assign secs_sat   = (cmd_word.secs > MAX_PERIOD_W'(SEC_MAX)) ? SEC_MAX :
                       SEC_W'(cmd_word.secs);
   assign stop_ok    = (int'(cmd_word.slot_in) < NUM_SLOTS) && used_ff[stop_idx];
   assign stop_idx   = SLOT_IDX_W'(cmd_word.slot_in);

   assign room      = (rq_cnt_ff != RQ_CNT_W'(RSP_DEPTH));
   assign empty     = (rq_cnt_ff == '0);
   assign rsp_word  = rq_ff[rq_rd_ff];
   assign rsp_taken = pop && !empty;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      p_valid_in    = p_valid_ff;
      p_slot_in     = p_slot_ff;
      used_in       = used_ff;
      active_in     = active_ff;
      used_count_in = used_count_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      exp_cnt_in    = exp_cnt_ff;
      cmd_pop       = 1'b0;
      push_rsp      = 1'b0;
      push_word     = make_rsp(ST_OK, '0, 1'b1);
      ram_wr_en     = 1'b0;
      ram_wr_addr   = p_slot_ff;
      ram_wr_data   = {ram_reload, rem_dec};
      ram_rd_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty && room) begin
               case (cmd_word.op)
                  FUNC_START: begin
                     if (cmd_word.bad_period) begin
                        push_rsp  = 1'b1;
                        push_word = make_rsp(ST_BAD_PERIOD, '0, 1'b1);
                        cmd_pop   = 1'b1;
                     end else if (used_count_ff >= max_active) begin
                        push_rsp  = 1'b1;
                        push_word = make_rsp(ST_FULL, '0, 1'b1);
                        cmd_pop   = 1'b1;
                     end else begin
                        scan_in  = '0;
                        state_in = S_START_SCAN;
                     end
                  end
                  FUNC_STOP: begin
                     push_rsp = 1'b1;
                     cmd_pop  = 1'b1;
                     if (stop_ok) begin
                        active_in[stop_idx] = 1'b0;
                        push_word = make_rsp(ST_OK, '0, 1'b1);
                     end else begin
                        push_word = make_rsp(ST_BAD_SLOT, '0, 1'b1);
                     end
                  end
                  FUNC_TICK: begin
                     scan_in       = '0;
                     p_valid_in    = 1'b0;
                     pend_valid_in = 1'b0;
                     exp_cnt_in    = '0;
                     state_in      = S_TICK_SCAN;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         S_START_SCAN: begin
            if (room) begin
               if (scan_ff == SLOT_CNT_W'(NUM_SLOTS)) begin
                  push_rsp  = 1'b1;
                  push_word = make_rsp(ST_FULL, '0, 1'b1);
                  cmd_pop   = 1'b1;
                  state_in  = S_IDLE;
               end else if (!used_ff[scan_idx]) begin
                  used_in[scan_idx]   = 1'b1;
                  active_in[scan_idx] = 1'b1;
                  used_count_in       = used_count_ff + 1'b1;
                  ram_wr_en           = 1'b1;
                  ram_wr_addr         = scan_idx;
                  ram_wr_data         = {secs_sat, secs_sat};
                  push_rsp            = 1'b1;
                  push_word           = make_rsp(ST_OK, SLOT_W'(scan_idx), 1'b1);
                  cmd_pop             = 1'b1;
                  state_in            = S_IDLE;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end

         S_TICK_SCAN: begin
            // read slot scan_ff while updating slot p_slot_ff from last read
            if (room) begin
               if (p_valid_ff && p_used) begin
                  if (!p_active) begin
                     used_in[p_slot_ff] = 1'b0;
                     if (used_count_ff != '0) begin
                        used_count_in = used_count_ff - 1'b1;
                     end
                  end else begin
                     ram_wr_en = 1'b1;
                     if (rem_dec == '0) begin
                        ram_wr_data = {ram_reload, ram_reload};
                        if (exp_cnt_ff < RESULT_CNT_W'(MAX_RESULTS)) begin
                           if (pend_valid_ff) begin
                              push_rsp  = 1'b1;
                              push_word = make_rsp(ST_EXPIRY, SLOT_W'(pend_slot_ff), 1'b0);
                           end
                           pend_valid_in = 1'b1;
                           pend_slot_in  = p_slot_ff;
                           exp_cnt_in    = exp_cnt_ff + 1'b1;
                        end
                     end
                  end
               end
               if (scan_ff == SLOT_CNT_W'(NUM_SLOTS)) begin
                  p_valid_in = 1'b0;
                  state_in   = S_TICK_DONE;
               end else begin
                  ram_rd_en  = 1'b1;
                  p_valid_in = 1'b1;
                  p_slot_in  = scan_idx;
                  scan_in    = scan_ff + 1'b1;
               end
            end
         end

         S_TICK_DONE: begin
            if (room) begin
               push_rsp = 1'b1;
               if (pend_valid_ff) begin
                  push_word = make_rsp(ST_EXPIRY, SLOT_W'(pend_slot_ff), 1'b1);
               end else begin
                  push_word = make_rsp(ST_NO_EXPIRY, '0, 1'b1);
               end
               pend_valid_in = 1'b0;
               cmd_pop       = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (push_rsp) begin
         rq_wr_in = (rq_wr_ff == RQ_PTR_W'(RSP_DEPTH - 1)) ? '0 : rq_wr_ff + 1'b1;
      end
      if (rsp_taken) begin
         rq_rd_in = (rq_rd_ff == RQ_PTR_W'(RSP_DEPTH - 1)) ? '0 : rq_rd_ff + 1'b1;
      end
      if (push_rsp && !rsp_taken) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rsp_taken && !push_rsp) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         p_valid_ff    <= 1'b0;
         used_ff       <= '0;
         active_ff     <= '0;
         used_count_ff <= '0;
         pend_valid_ff <= 1'b0;
         exp_cnt_ff    <= '0;
         rq_wr_ff      <= '0;
         rq_rd_ff      <= '0;
         rq_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         p_valid_ff    <= p_valid_in;
         used_ff       <= used_in;
         active_ff     <= active_in;
         used_count_ff <= used_count_in;
         pend_valid_ff <= pend_valid_in;
         exp_cnt_ff    <= exp_cnt_in;
         rq_wr_ff      <= rq_wr_in;
         rq_rd_ff      <= rq_rd_in;
         rq_cnt_ff     <= rq_cnt_in;
      end
      p_slot_ff    <= p_slot_in;
      pend_slot_ff <= pend_slot_in;
      if (push_rsp) begin
         rq_ff[rq_wr_ff] <= push_word;
      end
   end

endmodule

### rtl/periodic_timer_bank_core.sv
// Periodic timer bank, top level: config registers, front end, command queue, slot engine.
// Depends on ptb_pkg, ptb_front, ptb_cmd_fifo and ptb_back.
//
// Request words are taken whenever the two-entry command queue has room, and
// result words wait in a two-entry output queue until popped. The slot engine
// handles one command at a time: a stop is answered straight from idle, a
// start walks the occupancy flags from slot 0 one slot per cycle, and a tick
// walks every slot through the second-counter RAM one slot per cycle; both
// walks stall while the output queue is full. The counter RAM needs no
// clearing pass after reset; a start always writes a slot's counters before
// they are used.
`timescale 1ns / 1ps

module periodic_timer_bank_core import ptb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_word,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_word,
   input  logic                   valid,
   output logic                   ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0]      max_active_ff;
   logic [MAX_PERIOD_W-1:0] max_period_ms_ff;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wr_word, cmd_rd_word;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_active_ff    <= MAX_ACTIVE_RESET;
         max_period_ms_ff <= MAX_PERIOD_RESET;
      end else if (valid && ready) begin
         case (csr_index)
            CSR_MAX_ACTIVE:    max_active_ff    <= COUNT_W'(csr_wdata);
            CSR_MAX_PERIOD_MS: max_period_ms_ff <= MAX_PERIOD_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   ptb_front u_front (
      .push          (push),
      .req_word      (req_word),
      .full          (full),
      .max_period_ms (max_period_ms_ff),
      .cmd_push      (cmd_push),
      .cmd_word      (cmd_wr_word),
      .cmd_full      (cmd_full)
   );

   ptb_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_word (cmd_wr_word),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_word (cmd_rd_word),
      .empty   (cmd_empty)
   );

   ptb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_word   (cmd_rd_word),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .max_active (max_active_ff),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word)
   );

endmodule

### rtl/ptb_checker.sv
// Port-level checker for the periodic timer bank, bound to the top level.
// Depends on ptb_pkg and periodic_timer_bank_core_macros.svh.
`timescale 1ns / 1ps
`include "periodic_timer_bank_core_macros.svh"

module ptb_checker import ptb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_word
);

   `PTB_ASSERT(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp_word), "result word changed while waiting")

   `PTB_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) |-> empty, "result queue not empty after reset")

   `PTB_ASSERT(a_only_expiry_not_last, !empty && rsp_word.status != ST_EXPIRY |-> rsp_word.last, "non-expiry word without last")

   `PTB_ASSERT(a_error_slot_zero, !empty && (rsp_word.status == ST_BAD_PERIOD || rsp_word.status == ST_FULL || rsp_word.status == ST_BAD_SLOT || rsp_word.status == ST_NO_EXPIRY) |-> rsp_word.slot_out == '0, "slot not zero on error word")

endmodule

bind periodic_timer_bank_core ptb_checker u_ptb_checker (.*);
